// ----- sv/four_level_page_table_walker_defines.svh -----
// Assertion macros shared by the page table walker checks.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, ignored while reset is held.
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- sv/ptw_pkg.sv -----
// Types, codes and helpers for the four-level page table walker.
package ptw_pkg;

  localparam int IDX_W = 9;

  localparam logic [1:0] KIND_MAP   = 2'd0;
  localparam logic [1:0] KIND_UNMAP = 2'd1;
  localparam logic [1:0] KIND_XLATE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOMAP = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [63:0] PTE_P = 64'h1;
  localparam logic [63:0] PTE_W = 64'h2;
  localparam logic [63:0] PTE_U = 64'h4;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] paddr;
  } ptw_res_t;

  // Table index of one level; level 0 is the root.
  function automatic logic [IDX_W-1:0] level_idx(input logic [47:0] va,
                                                 input logic [1:0] lv);
    logic [IDX_W-1:0] idx;
    unique case (lv)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ----- sv/ptw_store.sv -----
// Single-port frame store holding all table entries.
module ptw_store #(
  parameter int TABLE_FRAMES = 16
) (
  input  logic                                            clk,
  input  logic                                            we,
  input  logic [$clog2(TABLE_FRAMES)+ptw_pkg::IDX_W-1:0]  addr,
  input  logic [63:0]                                     wdata,
  output logic [63:0]                                     rdata
);
  import ptw_pkg::*;

  localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/ptw_walk.sv -----
// Walk sequencer: level reads, frame allocation, frame clearing, leaf update.
module ptw_walk #(
  parameter int TABLE_FRAMES = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [1:0]                                      in_kind,
  input  logic [47:0]                                     in_vaddr,
  input  logic [39:0]                                     in_phys_page,
  input  logic [8:0]                                      in_leaf_flags,
  input  logic                                            in_no_execute,
  output logic                                            res_valid,
  input  logic                                            res_ready,
  output ptw_pkg::ptw_res_t                               res,
  output logic                                            mem_we,
  output logic [$clog2(TABLE_FRAMES)+ptw_pkg::IDX_W-1:0]  mem_addr,
  output logic [63:0]                                     mem_wdata,
  input  logic [63:0]                                     mem_rdata
);
  import ptw_pkg::*;

  localparam int FW = $clog2(TABLE_FRAMES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_LEAF = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [47:0]      va_r, va_nxt;
  logic [39:0]      pp_r, pp_nxt;
  logic [8:0]       fl_r, fl_nxt;
  logic             nx_r, nx_nxt;
  logic [FW-1:0]    fr_r, fr_nxt;
  logic [1:0]       lv_r, lv_nxt;
  logic [FW-1:0]    alloc_r, alloc_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [FW:0]      nf_r, nf_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [51:0]      pa_r, pa_nxt;

  logic             is_map;
  logic             present;
  logic             child_ok;
  logic             full;
  logic [IDX_W-1:0] idx;

  assign is_map   = (kind_r == KIND_MAP);
  assign present  = mem_rdata[0];
  // A link naming a frame outside the store counts as absent.
  assign child_ok = present && (mem_rdata[51:12] < 40'(TABLE_FRAMES));
  assign full     = (nf_r == (FW+1)'(TABLE_FRAMES));
  assign idx      = level_idx(va_r, lv_r);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    va_nxt      = va_r;
    pp_nxt      = pp_r;
    fl_nxt      = fl_r;
    nx_nxt      = nx_r;
    fr_nxt      = fr_r;
    lv_nxt      = lv_r;
    alloc_nxt   = alloc_r;
    clr_idx_nxt = clr_idx_r;
    nf_nxt      = nf_r;
    status_nxt  = status_r;
    pa_nxt      = pa_r;
    mem_we      = 1'b0;
    mem_addr    = {fr_r, idx};
    mem_wdata   = '0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_addr    = {alloc_r, clr_idx_r};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          // Frame 0 is only swept after reset; any other frame is a new table.
          state_nxt = (alloc_r == '0) ? S_IDLE : S_LINK;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          va_nxt     = in_vaddr;
          pp_nxt     = in_phys_page;
          fl_nxt     = in_leaf_flags;
          nx_nxt     = in_no_execute;
          fr_nxt     = '0;
          lv_nxt     = 2'd0;
          status_nxt = ST_DONE;
          pa_nxt     = '0;
          case (in_kind) inside
            KIND_MAP, KIND_UNMAP, KIND_XLATE: state_nxt = S_RD;
            default:                          state_nxt = S_RESP;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (lv_r != 2'd3) begin
          if (child_ok) begin
            fr_nxt    = mem_rdata[12 +: FW];
            lv_nxt    = lv_r + 1'b1;
            state_nxt = (is_map && lv_r == 2'd2) ? S_LEAF : S_RD;
          end else if (is_map) begin
            if (full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              alloc_nxt   = nf_r[FW-1:0];
              nf_nxt      = nf_r + 1'b1;
              clr_idx_nxt = '0;
              state_nxt   = S_CLR;
            end
          end else begin
            status_nxt = ST_NOMAP;
            state_nxt  = S_RESP;
          end
        end else begin
          if (!present) begin
            status_nxt = ST_NOMAP;
            state_nxt  = S_RESP;
          end else if (kind_r == KIND_UNMAP) begin
            state_nxt = S_LEAF;
          end else begin
            pa_nxt    = {mem_rdata[51:12], va_r[11:0]};
            state_nxt = S_RESP;
          end
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {12'd0, 40'(alloc_r), 12'(PTE_P | PTE_W | PTE_U)};
        fr_nxt    = alloc_r;
        lv_nxt    = lv_r + 1'b1;
        state_nxt = (lv_r == 2'd2) ? S_LEAF : S_RD;
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = is_map ? {nx_r, 11'd0, pp_r, 3'd0, fl_r | 9'(PTE_P)} : 64'd0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      alloc_r   <= '0;
      clr_idx_r <= '0;
      nf_r      <= (FW+1)'(1);
    end else begin
      state_r   <= state_nxt;
      alloc_r   <= alloc_nxt;
      clr_idx_r <= clr_idx_nxt;
      nf_r      <= nf_nxt;
    end
    kind_r   <= kind_nxt;
    va_r     <= va_nxt;
    pp_r     <= pp_nxt;
    fl_r     <= fl_nxt;
    nx_r     <= nx_nxt;
    fr_r     <= fr_nxt;
    lv_r     <= lv_nxt;
    status_r <= status_nxt;
    pa_r     <= pa_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign res      = '{status: status_r, paddr: pa_r};

endmodule

// ----- sv/four_level_page_table_walker.sv -----
// Top level of the four-level page table walker with its internal frame store.
//
//   channel  direction  beat contents
//   -------  ---------  -----------------------------------------------------
//   in_      input      kind, vaddr, phys_page, leaf_flags, no_execute
//   out_     output     status, paddr (one beat per input beat)
//
// After reset the walker sweeps frame 0 clean, one entry a cycle, with
// in_ready low. A beat is then latched, each level read is issued and
// then checked against the registered store data, and the result is handed
// to the output register. A translate that reaches the leaf returns its
// address, an unmap clears the leaf, and a map writes it; each new table a
// map creates adds a sweep of that frame plus one link write. All of this
// runs through the single port of the frame store. The output
// register holds a finished result while the walker takes the next beat;
// out_ready low stalls the walker only once a second result is ready.
module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_vaddr,
  input  logic [39:0] in_phys_page,
  input  logic [8:0]  in_leaf_flags,
  input  logic        in_no_execute,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [51:0] out_paddr
);
  import ptw_pkg::*;

  localparam int AW = $clog2(TABLE_FRAMES) + IDX_W;

  // Frame store port, driven by the sequencer.
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata;
  logic [63:0]   mem_rdata;

  // Finished result from the sequencer and its handoff.
  logic          res_valid;
  logic          res_ready;
  ptw_res_t      res;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [51:0]   out_paddr_r, out_paddr_nxt;

  ptw_store #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ptw_walk #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_vaddr      (in_vaddr),
    .in_phys_page  (in_phys_page),
    .in_leaf_flags (in_leaf_flags),
    .in_no_execute (in_no_execute),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

  // Take a new result whenever the output register is empty or drains now.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_paddr_nxt  = out_paddr_r;
    if (res_valid && res_ready) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res.status;
      out_paddr_nxt  = res.paddr;
    end else if (out_ready) begin
      // Drop the beat once it is taken.
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_paddr_r  <= out_paddr_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_paddr  = out_paddr_r;

endmodule

// ----- sv/ptw_checker.sv -----
// Port-level checks for the page table walker, bound to the top level.
`include "four_level_page_table_walker_defines.svh"

module ptw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [51:0] out_paddr
);
  import ptw_pkg::*;

  `PTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_paddr))
  `PTW_ASSERT_NOW(a_fail_no_addr, clk, rst_n, out_valid && out_status != ST_DONE, out_paddr == 52'd0)
  `PTW_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_status == ST_DONE || out_status == ST_NOMAP || out_status == ST_FULL)
  `PTW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
